[rtl/core/lis_pkg.sv]
// Shared constants and types for the longest increasing subsequence mask block.
package lis_pkg;

  // Default sizing handed to the top level parameters.
  localparam int DEF_MAX_ELEMENTS = 1024;
  localparam int DEF_VALUE_WIDTH  = 32;

  // Fixed widths of the result fields.
  localparam int WORD_BITS    = 64;
  localparam int WORD_INDEX_W = 4;
  localparam int SEQ_LEN_W    = 11;
  localparam int END_POS_W    = 10;

  // Result of the shared compare unit.
  typedef struct packed {
    logic val_lt;    // stored value is strictly below the reference value
    logic score_gt;  // stored score plus one is above the reference score
    logic score_eq;  // stored score plus one equals the reference score
  } cmp_res_t;

  // Write enables of the value and score stores.
  typedef struct packed {
    logic val;
    logic score;
  } wr_en_t;

endpackage

[rtl/core/lis_dp_mem.sv]
// Value and score stores with one shared write port and one registered read port.
module lis_dp_mem #(
  parameter int DEPTH = lis_pkg::DEF_MAX_ELEMENTS,
  parameter int VW    = lis_pkg::DEF_VALUE_WIDTH,
  parameter int SW    = $clog2(lis_pkg::DEF_MAX_ELEMENTS + 1)
) (
  input  logic                     clk,
  input  lis_pkg::wr_en_t          wr_en,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [VW-1:0]            wval,
  input  logic [SW-1:0]            wscore,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [VW-1:0]            rd_val,
  output logic [SW-1:0]            rd_score
);

  logic [VW-1:0] val_mem   [DEPTH];
  logic [SW-1:0] score_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en.val) begin
      val_mem[waddr] <= wval;
    end
    if (wr_en.score) begin
      score_mem[waddr] <= wscore;
    end
  end

  // Read data is registered; it appears in the cycle after the address.
  always_ff @(posedge clk) begin
    rd_val   <= val_mem[raddr];
    rd_score <= score_mem[raddr];
  end

endmodule

[rtl/core/lis_cmp_unit.sv]
// Shared compare unit used by both the score pass and the backward walk.
module lis_cmp_unit #(
  parameter int VW = lis_pkg::DEF_VALUE_WIDTH,
  parameter int SW = $clog2(lis_pkg::DEF_MAX_ELEMENTS + 1)
) (
  input  logic [VW-1:0]     rd_val,
  input  logic [VW-1:0]     ref_val,
  input  logic [SW-1:0]     rd_score,
  input  logic [SW-1:0]     ref_score,
  output lis_pkg::cmp_res_t res
);

  logic [SW:0] inc_score;
  logic [SW:0] ref_ext;

  assign inc_score    = {1'b0, rd_score} + {{SW{1'b0}}, 1'b1};
  assign ref_ext      = {1'b0, ref_score};
  assign res.val_lt   = rd_val < ref_val;
  assign res.score_gt = inc_score > ref_ext;
  assign res.score_eq = inc_score == ref_ext;

endmodule

[rtl/core/longest_increasing_subsequence_mask.sv]
// Top level of the longest increasing subsequence mask block: sequencer, mask store, output.
//
// The block takes a run of unsigned values, one beat per element, up to and including
// the beat marked with in_last_element, and then reports which elements form the longest
// strictly increasing subsequence as 64-bit mask words, one result beat per 64 elements
// of the run, each carrying the sequence length, the index of its last element and an
// overflow flag for elements dropped because the store was full. Loading accepts one beat
// per cycle. After the final beat the input stalls while one compare unit, fed from the
// single read port of the value and score store, runs the quadratic score pass, which
// dominates the run time: each element is compared with every earlier one and its score
// written. The backward walk then runs from the chosen end down to position zero, and each
// mask word is read from the mask store and held until the receiver takes it. Among equal
// top scores the latest position is chosen as the end, and equal values never count as
// increasing. The stores need no clearing: only entries written in the current run are
// read, and mask rows beyond the chosen end are reported as zero in place of the stored
// row. The input is ready again in the cycle after the final mask word is taken.
module longest_increasing_subsequence_mask #(
  parameter int MAX_ELEMENTS = lis_pkg::DEF_MAX_ELEMENTS,
  parameter int VALUE_WIDTH  = lis_pkg::DEF_VALUE_WIDTH
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // Input channel.
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [VALUE_WIDTH-1:0]                in_value,
  input  logic                                  in_last_element,
  // Result channel.
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [lis_pkg::WORD_BITS-1:0]         out_mask_word,
  output logic [lis_pkg::WORD_INDEX_W-1:0]      out_word_index,
  output logic [lis_pkg::SEQ_LEN_W-1:0]         out_sequence_length,
  output logic [lis_pkg::END_POS_W-1:0]         out_end_position,
  output logic                                  out_overflow,
  output logic                                  out_last_word
);

  localparam int WB   = lis_pkg::WORD_BITS;
  localparam int AW   = $clog2(MAX_ELEMENTS);
  localparam int CW   = $clog2(MAX_ELEMENTS + 1);
  localparam int SW   = CW;
  localparam int LW   = $clog2(WB);
  localparam int ROWS = (MAX_ELEMENTS + WB - 1) / WB;
  localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;

  // Sequencer states.
  localparam logic [3:0] S_LOAD   = 4'd0;
  localparam logic [3:0] S_PFETCH = 4'd1;
  localparam logic [3:0] S_PLOAD  = 4'd2;
  localparam logic [3:0] S_SCAN   = 4'd3;
  localparam logic [3:0] S_WRITE  = 4'd4;
  localparam logic [3:0] S_MFETCH = 4'd5;
  localparam logic [3:0] S_MLOAD  = 4'd6;
  localparam logic [3:0] S_WALK   = 4'd7;
  localparam logic [3:0] S_ORD    = 4'd8;
  localparam logic [3:0] S_OLOAD  = 4'd9;
  localparam logic [3:0] S_OSEND  = 4'd10;

  // Control state.
  logic [3:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          ovf_r, ovf_nxt;
  logic [AW-1:0] end_r, end_nxt;
  logic          vld_r, vld_nxt;
  logic [RW-1:0] w_r, w_nxt;
  logic          out_valid_r, out_valid_nxt;

  // Working registers of the passes.
  logic [AW-1:0]          p_r, p_nxt;
  logic [AW-1:0]          q_r, q_nxt;
  logic [VALUE_WIDTH-1:0] ref_val_r, ref_val_nxt;
  logic [SW-1:0]          ref_score_r, ref_score_nxt;
  logic [SW-1:0]          endscore_r, endscore_nxt;
  logic [WB-1:0]          acc_r, acc_nxt;

  // Output payload registers.
  logic [WB-1:0]                        out_mask_r, out_mask_nxt;
  logic [lis_pkg::WORD_INDEX_W-1:0]     out_index_r, out_index_nxt;
  logic [lis_pkg::SEQ_LEN_W-1:0]        out_len_r, out_len_nxt;
  logic [lis_pkg::END_POS_W-1:0]        out_end_r, out_end_nxt;
  logic                                 out_ovf_r, out_ovf_nxt;
  logic                                 out_last_r, out_last_nxt;

  // Store ports.
  lis_pkg::wr_en_t        wr_en;
  logic [AW-1:0]          waddr;
  logic [AW-1:0]          raddr;
  logic [VALUE_WIDTH-1:0] rd_val;
  logic [SW-1:0]          rd_score;
  lis_pkg::cmp_res_t      cmp;

  // Mask store, one 64-bit row per chunk of the run.
  logic [WB-1:0] mask_mem [ROWS];
  logic [WB-1:0] mask_rd_r;
  logic          mask_we;
  logic [RW-1:0] mask_waddr;
  logic [WB-1:0] mask_wdata;

  // Bit deposit into the row accumulator during the walk.
  logic          dep_en;
  logic          dep_first;
  logic          dep_bit;
  logic [AW-1:0] dep_pos;
  logic [WB-1:0] dep_word;

  logic          in_accept;
  logic          walk_hit;
  logic [RW-1:0] last_row;
  logic [RW-1:0] end_row;

  assign in_stall  = (state_r != S_LOAD);
  assign in_accept = in_valid && !in_stall;

  assign last_row = RW'((count_r - CW'(1)) >> LW);
  assign end_row  = RW'(end_r >> LW);
  assign walk_hit = cmp.val_lt && cmp.score_eq;

  lis_dp_mem #(
    .DEPTH (MAX_ELEMENTS),
    .VW    (VALUE_WIDTH),
    .SW    (SW)
  ) u_store (
    .clk      (clk),
    .wr_en    (wr_en),
    .waddr    (waddr),
    .wval     (in_value),
    .wscore   (ref_score_r),
    .raddr    (raddr),
    .rd_val   (rd_val),
    .rd_score (rd_score)
  );

  // The reference registers hold the current element and best score in the score pass,
  // and the last member found in the walk, so the unit needs no input selection.
  lis_cmp_unit #(
    .VW (VALUE_WIDTH),
    .SW (SW)
  ) u_cmp (
    .rd_val    (rd_val),
    .ref_val   (ref_val_r),
    .rd_score  (rd_score),
    .ref_score (ref_score_r),
    .res       (cmp)
  );

  always_ff @(posedge clk) begin
    if (mask_we) begin
      mask_mem[mask_waddr] <= mask_wdata;
    end
    mask_rd_r <= mask_mem[w_r];
  end

  // A deposit sets one bit in the row being built; the row is written out when the
  // walk reaches its lowest bit, since the walk runs from high to low positions.
  always_comb begin
    dep_word   = (dep_first ? '0 : acc_r) | (WB'(dep_bit) << dep_pos[LW-1:0]);
    mask_we    = dep_en && (dep_pos[LW-1:0] == '0);
    mask_waddr = RW'(dep_pos >> LW);
    mask_wdata = dep_word;
    acc_nxt    = acc_r;
    if (dep_en) begin
      acc_nxt = mask_we ? '0 : dep_word;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    end_nxt       = end_r;
    vld_nxt       = vld_r;
    w_nxt         = w_r;
    out_valid_nxt = out_valid_r;
    p_nxt         = p_r;
    q_nxt         = q_r;
    ref_val_nxt   = ref_val_r;
    ref_score_nxt = ref_score_r;
    endscore_nxt  = endscore_r;
    out_mask_nxt  = out_mask_r;
    out_index_nxt = out_index_r;
    out_len_nxt   = out_len_r;
    out_end_nxt   = out_end_r;
    out_ovf_nxt   = out_ovf_r;
    out_last_nxt  = out_last_r;
    wr_en         = '0;
    waddr         = p_r;
    raddr         = q_r;
    dep_en        = 1'b0;
    dep_first     = 1'b0;
    dep_bit       = 1'b0;
    dep_pos       = q_r;

    unique case (state_r)
      S_LOAD: begin
        waddr = AW'(count_r);
        if (in_accept) begin
          if (count_r != CW'(MAX_ELEMENTS)) begin
            wr_en.val = 1'b1;
            count_nxt = count_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last_element) begin
            p_nxt        = '0;
            endscore_nxt = '0;
            state_nxt    = S_PFETCH;
          end
        end
      end
      S_PFETCH: begin
        raddr     = p_r;
        state_nxt = S_PLOAD;
      end
      S_PLOAD: begin
        ref_val_nxt   = rd_val;
        ref_score_nxt = SW'(1);
        q_nxt         = '0;
        vld_nxt       = 1'b0;
        state_nxt     = S_SCAN;
      end
      S_SCAN: begin
        // Issue one earlier element per cycle and score the one read in the cycle before.
        raddr = q_r;
        if (vld_r && cmp.val_lt && cmp.score_gt) begin
          ref_score_nxt = rd_score + SW'(1);
        end
        if (q_r != p_r) begin
          q_nxt   = q_r + AW'(1);
          vld_nxt = 1'b1;
        end else begin
          vld_nxt   = 1'b0;
          state_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        wr_en.score = 1'b1;
        waddr       = p_r;
        if (ref_score_r >= endscore_r) begin
          end_nxt      = p_r;
          endscore_nxt = ref_score_r;
        end
        if (CW'(p_r) + CW'(1) == count_r) begin
          state_nxt = S_MFETCH;
        end else begin
          p_nxt     = p_r + AW'(1);
          state_nxt = S_PFETCH;
        end
      end
      S_MFETCH: begin
        raddr     = end_r;
        state_nxt = S_MLOAD;
      end
      S_MLOAD: begin
        ref_val_nxt   = rd_val;
        ref_score_nxt = endscore_r;
        q_nxt         = end_r;
        vld_nxt       = 1'b0;
        dep_en        = 1'b1;
        dep_first     = 1'b1;
        dep_bit       = 1'b1;
        dep_pos       = end_r;
        state_nxt     = S_WALK;
      end
      S_WALK: begin
        // Data in flight belongs to position q_r; the next lower position is issued.
        raddr = q_r - AW'(1);
        if (vld_r) begin
          dep_en  = 1'b1;
          dep_bit = walk_hit;
          dep_pos = q_r;
          if (walk_hit) begin
            ref_val_nxt   = rd_val;
            ref_score_nxt = rd_score;
          end
        end
        if (q_r != '0) begin
          q_nxt   = q_r - AW'(1);
          vld_nxt = 1'b1;
        end else begin
          vld_nxt   = 1'b0;
          w_nxt     = '0;
          state_nxt = S_ORD;
        end
      end
      S_ORD: begin
        state_nxt = S_OLOAD;
      end
      S_OLOAD: begin
        out_mask_nxt  = (w_r > end_row) ? '0 : mask_rd_r;
        out_index_nxt = lis_pkg::WORD_INDEX_W'(w_r);
        out_len_nxt   = lis_pkg::SEQ_LEN_W'(endscore_r);
        out_end_nxt   = lis_pkg::END_POS_W'(end_r);
        out_ovf_nxt   = ovf_r;
        out_last_nxt  = (w_r == last_row);
        out_valid_nxt = 1'b1;
        state_nxt     = S_OSEND;
      end
      S_OSEND: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            count_nxt = '0;
            ovf_nxt   = 1'b0;
            state_nxt = S_LOAD;
          end else begin
            w_nxt     = w_r + RW'(1);
            state_nxt = S_ORD;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      end_r       <= '0;
      vld_r       <= 1'b0;
      w_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      end_r       <= end_nxt;
      vld_r       <= vld_nxt;
      w_r         <= w_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r         <= p_nxt;
    q_r         <= q_nxt;
    ref_val_r   <= ref_val_nxt;
    ref_score_r <= ref_score_nxt;
    endscore_r  <= endscore_nxt;
    acc_r       <= acc_nxt;
    out_mask_r  <= out_mask_nxt;
    out_index_r <= out_index_nxt;
    out_len_r   <= out_len_nxt;
    out_end_r   <= out_end_nxt;
    out_ovf_r   <= out_ovf_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_mask_word       = out_mask_r;
  assign out_word_index      = out_index_r;
  assign out_sequence_length = out_len_r;
  assign out_end_position    = out_end_r;
  assign out_overflow        = out_ovf_r;
  assign out_last_word       = out_last_r;

  // The element count never exceeds the store depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_ELEMENTS))
    else $error("element count beyond store depth");

  // Dropped elements are only possible once the store is full.
  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> (count_r == CW'(MAX_ELEMENTS)))
    else $error("overflow flagged with room left in the store");

  // The scan index never passes the element being scored.
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (q_r <= p_r))
    else $error("scan index past current element");

  // A result beat never refers to a chunk beyond the run.
  a_word_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (w_r <= last_row))
    else $error("mask word beyond the run");

  // Once a beat is taken, the next beat comes only after a fresh row read.
  a_beat_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_stall) |=> !out_valid_r)
    else $error("result beat repeated without a new row read");

endmodule
